/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("display list coprocessor check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define DLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("display list coprocessor check failed");

`endif

/* sv/dlc_pkg.sv */
`timescale 1ns / 1ps

package dlc_pkg;

  // Item kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_INSTR = 2'd2;

  // Registers decoded inside the block
  localparam logic [8:0] REG_L1_HI  = 9'h080;
  localparam logic [8:0] REG_L1_LO  = 9'h082;
  localparam logic [8:0] REG_L2_HI  = 9'h084;
  localparam logic [8:0] REG_L2_LO  = 9'h086;
  localparam logic [8:0] REG_JUMP1  = 9'h088;
  localparam logic [8:0] REG_JUMP2  = 9'h08a;
  localparam logic [8:0] REG_MASK   = 9'h1fe;

  // End-of-list marker
  localparam logic [15:0] END_FIRST  = 16'hffff;
  localparam logic [15:0] END_SECOND = 16'hfffe;

  localparam int CNT_W = 13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  line_number;
    logic [18:0] start_address;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [8:0]  write_register;
    logic [15:0] write_data;
    logic        fetch_valid;
    logic [18:0] fetch_address;
    logic        halted;
    logic [9:0]  wake_line;
  } result_t;

  // Only the low 19 bits of a list address can reach the program counter.
  typedef struct packed {
    logic [18:0]      pc;
    logic [18:0]      list_one;
    logic [18:0]      list_two;
    logic [9:0]       wake;
    logic             stopped;
    logic [8:0]       beam_line;
    logic [CNT_W-1:0] count;
    logic             running;
  } state_t;

endpackage

/* sv/dlc_in_if.sv */
`timescale 1ns / 1ps

interface dlc_in_if;
  import dlc_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [8:0]  line_number;
  logic [18:0] start_address;
  logic [15:0] first_word;
  logic [15:0] second_word;

  modport source (
    output valid, kind, line_number, start_address, first_word, second_word,
    input  ready
  );
  modport sink (
    input  valid, kind, line_number, start_address, first_word, second_word,
    output ready
  );
endinterface

/* sv/dlc_out_if.sv */
`timescale 1ns / 1ps

interface dlc_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [8:0]  write_register;
  logic [15:0] write_data;
  logic        fetch_valid;
  logic [18:0] fetch_address;
  logic        halted;
  logic [9:0]  wake_line;

  modport source (
    output valid, write_valid, write_register, write_data, fetch_valid,
           fetch_address, halted, wake_line,
    input  ready
  );
  modport sink (
    input  valid, write_valid, write_register, write_data, fetch_valid,
           fetch_address, halted, wake_line,
    output ready
  );
endinterface

/* sv/dlc_exec.sv */
`timescale 1ns / 1ps

module dlc_exec import dlc_pkg::*; #(
  parameter int CHIP_BYTES            = 524288,
  parameter int INSTRUCTIONS_PER_LINE = 4096
) (
  input  item_t   item,
  input  state_t  state,
  output state_t  state_next,
  output result_t res
);

  localparam logic [18:0]      ADDR_MASK = 19'((CHIP_BYTES - 1) & 'h7FFFF);
  localparam logic [CNT_W-1:0] CAP       = CNT_W'(INSTRUCTIONS_PER_LINE);

  logic [7:0]       target;
  logic [7:0]       mask;
  logic             reached;
  logic [9:0]       wake_base;
  logic [9:0]       wake_calc;
  logic [CNT_W-1:0] cnt_inc;
  logic [8:0]       reg_sel;
  logic             is_end;

  always_comb begin
    target    = item.first_word[15:8];
    mask      = {1'b1, item.second_word[14:8]};
    reached   = (state.beam_line[7:0] & mask) >= (target & mask);
    wake_base = {1'b0, state.beam_line[8], target};
    wake_calc = (wake_base <= {1'b0, state.beam_line}) ? wake_base + 10'h100 : wake_base;
    cnt_inc   = state.count + CNT_W'(1);
    reg_sel   = item.first_word[8:0] & REG_MASK;
    is_end    = (item.first_word == END_FIRST) && (item.second_word == END_SECOND);
  end

  always_comb begin
    state_next         = state;
    res.write_valid    = 1'b0;
    res.write_register = '0;
    res.write_data     = '0;

    case (item.kind)
      KIND_FRAME: begin
        state_next.pc        = item.start_address & ADDR_MASK;
        state_next.list_one  = '0;
        state_next.list_two  = '0;
        state_next.wake      = '0;
        state_next.stopped   = 1'b0;
        state_next.beam_line = '0;
        state_next.count     = '0;
        state_next.running   = 1'b0;
      end
      KIND_LINE: begin
        state_next.beam_line = item.line_number;
        if (!state.stopped && (state.running || {1'b0, item.line_number} >= state.wake)) begin
          state_next.running = 1'b1;
          state_next.count   = '0;
        end
      end
      KIND_INSTR: begin
        if (state.running) begin
          state_next.count = cnt_inc;
          if (!item.first_word[0]) begin
            // MOVE
            state_next.pc      = (state.pc + 19'd4) & ADDR_MASK;
            res.write_valid    = 1'b1;
            res.write_register = reg_sel;
            res.write_data     = item.second_word;
            case (reg_sel)
              REG_L1_HI: state_next.list_one[18:16] = item.second_word[2:0];
              REG_L1_LO: state_next.list_one[15:0]  = {item.second_word[15:1], 1'b0};
              REG_L2_HI: state_next.list_two[18:16] = item.second_word[2:0];
              REG_L2_LO: state_next.list_two[15:0]  = {item.second_word[15:1], 1'b0};
              REG_JUMP1: begin
                state_next.pc      = state.list_one & ADDR_MASK;
                state_next.wake    = {1'b0, state.beam_line} + 10'd1;
                state_next.running = 1'b0;
              end
              REG_JUMP2: begin
                state_next.pc      = state.list_two & ADDR_MASK;
                state_next.wake    = {1'b0, state.beam_line} + 10'd1;
                state_next.running = 1'b0;
              end
              default: ;
            endcase
          end else if (!item.second_word[0]) begin
            // WAIT
            if (is_end) begin
              state_next.stopped = 1'b1;
              state_next.running = 1'b0;
            end else if (reached) begin
              state_next.pc = (state.pc + 19'd4) & ADDR_MASK;
            end else begin
              state_next.wake    = wake_calc;
              state_next.running = 1'b0;
            end
          end else begin
            // SKIP
            state_next.pc = (state.pc + (reached ? 19'd8 : 19'd4)) & ADDR_MASK;
          end
          if (state_next.running && cnt_inc >= CAP) begin
            state_next.stopped = 1'b1;
            state_next.running = 1'b0;
          end
        end
      end
      default: ;
    endcase

    res.fetch_valid   = state_next.running;
    res.fetch_address = state_next.pc;
    res.halted        = state_next.stopped;
    res.wake_line     = state_next.wake;
  end

endmodule

/* sv/display_list_coprocessor.sv */
// Path: an accepted item is held in the input register, then decoded into
// the result register once that register is empty or being drained.
// Throughput: one item per cycle while the result side keeps taking results;
// the single decode pass sets the rate. Reset (rst, synchronous, active high):
// copper halted until a frame start, all addresses, counters and wake line zero, pipeline registers empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module display_list_coprocessor import dlc_pkg::*; #(
  parameter int CHIP_BYTES            = 524288,
  parameter int INSTRUCTIONS_PER_LINE = 4096
) (
  input logic      clk,
  input logic      rst,
  dlc_in_if.sink   item,
  dlc_out_if.source result
);

  // Input register
  logic    in_valid;
  item_t   in_item;

  // Architectural copper state
  state_t  state;
  state_t  state_next;

  // Result register
  logic    out_valid;
  result_t out_res;
  result_t res_next;

  logic    advance;

  // Move the held item into the result register whenever that register is
  // empty or is being drained this cycle.
  assign advance    = !out_valid || result.ready;
  assign item.ready = !in_valid || advance;

  dlc_exec #(
    .CHIP_BYTES            (CHIP_BYTES),
    .INSTRUCTIONS_PER_LINE (INSTRUCTIONS_PER_LINE)
  ) u_exec (
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  // Capture a new transaction whenever the input register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_item.kind          <= item.kind;
      in_item.line_number   <= item.line_number;
      in_item.start_address <= item.start_address;
      in_item.first_word    <= item.first_word;
      in_item.second_word   <= item.second_word;
    end
  end

  // Commit the state update in the same edge that loads the result, so the
  // next item decodes against the state this one leaves behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pc        <= '0;
      state.list_one  <= '0;
      state.list_two  <= '0;
      state.wake      <= '0;
      state.stopped   <= 1'b1;
      state.beam_line <= '0;
      state.count     <= '0;
      state.running   <= 1'b0;
      out_valid       <= 1'b0;
    end else if (in_valid && advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.write_valid    = out_res.write_valid;
  assign result.write_register = out_res.write_register;
  assign result.write_data     = out_res.write_data;
  assign result.fetch_valid    = out_res.fetch_valid;
  assign result.fetch_address  = out_res.fetch_address;
  assign result.halted         = out_res.halted;
  assign result.wake_line      = out_res.wake_line;

  // A halted copper never executes.
  `DLC_ASSERT_IMP(a_stop_not_run, state.stopped, !state.running)
  // A held result never asks for a fetch while halted.
  `DLC_ASSERT_IMP(a_res_halt_fetch, out_valid, !(out_res.halted && out_res.fetch_valid))
  // An accepted transaction sits in the input register on the next cycle.
  `DLC_ASSERT_NEXT(a_accept_loads, item.valid && item.ready, in_valid)
  // A pending item with room downstream shows up as a result next cycle.
  `DLC_ASSERT_NEXT(a_item_drains, in_valid && advance, out_valid)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dlc_pkg::*;

  localparam int CHIP_BYTES = 524288;
  localparam int INSTR_CAP = 4096;
  localparam logic [18:0] ADDR_MASK = 19'(CHIP_BYTES - 1);

  // Kind 3 has no meaning to the block; it must be ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS = 1800;
  localparam int MAX_GAP = 11;
  localparam int HOLD_AT_RESULT = 600;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  localparam longint TIMEOUT_NS = 10_000_000;

  // Status right after reset: halted, nothing fetched, all zero.
  localparam result_t AFTER_RESET = '{1'b0, 9'h000, 16'h0000, 1'b0, 19'h00000, 1'b1, 10'h000};
  localparam result_t NO_STATUS = '0;

  typedef enum int {OP_MOVE, OP_WAIT, OP_SKIP, OP_END} instr_op_e;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t exp;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dlc_in_if  item_ch ();
  dlc_out_if result_ch ();

  display_list_coprocessor #(
    .CHIP_BYTES            (CHIP_BYTES),
    .INSTRUCTIONS_PER_LINE (INSTR_CAP)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // 12 ns period: 6 ns high, 6 ns low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Copper state as this bench tracks it. Advanced once per accepted
  // transaction, in the order the block sees them.
  // ---------------------------------------------------------------------
  logic [18:0] copper_pc;
  logic [31:0] list_one;
  logic [31:0] list_two;
  logic [9:0]  copper_wake;
  logic        copper_stopped;
  logic        copper_running;
  logic [8:0]  copper_line;
  logic [12:0] line_instr_count;

  // Expected copper status words, oldest first.
  result_t copper_status_q[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int move_count = 0;
  int sleep_count = 0;
  int halt_count = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  directed_row_t directed_rows[$];

  // Masked beam compare shared by WAIT and SKIP; bit 7 of the mask is
  // always set, horizontal position is ignored.
  function automatic bit beam_reached(input logic [8:0] ln, input logic [15:0] w1,
                                      input logic [15:0] w2);
    logic [7:0] mask;
    mask = {1'b1, w2[14:8]};
    return (ln[7:0] & mask) >= (w1[15:8] & mask);
  endfunction

  // Jump strobe: reload the counter from a list address, sleep until the
  // next line.
  function automatic void jump_to_list(input logic [31:0] addr);
    copper_pc = addr[18:0] & ADDR_MASK;
    copper_wake = {1'b0, copper_line} + 10'd1;
    copper_running = 1'b0;
    sleep_count++;
  endfunction

  function automatic void halt_copper();
    copper_stopped = 1'b1;
    copper_running = 1'b0;
    halt_count++;
  endfunction

  // Advance the copper by one transaction and return its status word.
  function automatic result_t copper_step(input item_t it);
    result_t    r;
    logic [9:0] wake;
    logic [8:0] wreg;
    r = '0;
    case (it.kind)
      KIND_FRAME: begin
        copper_pc = it.start_address & ADDR_MASK;
        list_one = '0;
        list_two = '0;
        copper_wake = '0;
        copper_stopped = 1'b0;
        copper_line = '0;
        line_instr_count = '0;
        copper_running = 1'b0;
      end
      KIND_LINE: begin
        copper_line = it.line_number;
        if (!copper_stopped && (copper_running || {1'b0, it.line_number} >= copper_wake)) begin
          copper_running = 1'b1;
          line_instr_count = '0;
        end
      end
      KIND_INSTR: begin
        if (copper_running) begin
          line_instr_count = line_instr_count + 13'd1;
          if (!it.first_word[0]) begin
            wreg = it.first_word[8:0] & REG_MASK;
            copper_pc = (copper_pc + 19'd4) & ADDR_MASK;
            r.write_valid = 1'b1;
            r.write_register = wreg;
            r.write_data = it.second_word;
            move_count++;
            case (wreg)
              REG_L1_HI: list_one = {it.second_word, list_one[15:0]};
              REG_L1_LO: list_one = {list_one[31:16], it.second_word & 16'hfffe};
              REG_L2_HI: list_two = {it.second_word, list_two[15:0]};
              REG_L2_LO: list_two = {list_two[31:16], it.second_word & 16'hfffe};
              REG_JUMP1: jump_to_list(list_one);
              REG_JUMP2: jump_to_list(list_two);
              default: ;
            endcase
          end else if (!it.second_word[0]) begin
            if (it.first_word == END_FIRST && it.second_word == END_SECOND) begin
              halt_copper();
            end else if (beam_reached(copper_line, it.first_word, it.second_word)) begin
              copper_pc = (copper_pc + 19'd4) & ADDR_MASK;
            end else begin
              wake = {1'b0, copper_line & 9'h100} | {2'b00, it.first_word[15:8]};
              if (wake <= {1'b0, copper_line}) wake = wake + 10'h100;
              copper_wake = wake;
              copper_running = 1'b0;
              sleep_count++;
            end
          end else begin
            copper_pc = (copper_pc + (beam_reached(copper_line, it.first_word, it.second_word)
                                      ? 19'd8 : 19'd4)) & ADDR_MASK;
          end
          if (copper_running && line_instr_count >= INSTR_CAP) halt_copper();
        end
      end
      default: ;
    endcase
    r.fetch_valid = copper_running;
    r.fetch_address = copper_pc;
    r.halted = copper_stopped;
    r.wake_line = copper_wake;
    return r;
  endfunction

  function automatic item_t rand_fields();
    item_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.line_number = 9'($urandom);
    it.start_address = 19'($urandom);
    it.first_word = 16'($urandom);
    it.second_word = 16'($urandom);
    return it;
  endfunction

  // Build one instruction pair. A tame MOVE never jumps and a tame WAIT
  // always passes.
  function automatic item_t make_instr(input instr_op_e op, input bit tame);
    item_t it;
    it = rand_fields();
    it.kind = KIND_INSTR;
    case (op)
      OP_MOVE: begin
        it.first_word[0] = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, tame ? 3 : 5))
            0: it.first_word[8:0] = REG_L1_HI;
            1: it.first_word[8:0] = REG_L1_LO;
            2: it.first_word[8:0] = REG_L2_HI;
            3: it.first_word[8:0] = REG_L2_LO;
            4: it.first_word[8:0] = REG_JUMP1;
            default: it.first_word[8:0] = REG_JUMP2;
          endcase
        end else if (tame && ((it.first_word[8:0] & REG_MASK) == REG_JUMP1 ||
                              (it.first_word[8:0] & REG_MASK) == REG_JUMP2)) begin
          it.first_word[8:0] = REG_L1_HI;
        end
      end
      OP_WAIT: begin
        it.first_word[0] = 1'b1;
        it.second_word[0] = 1'b0;
        // Aim near the current beam line half the time so both sides of
        // the compare get hit.
        if ($urandom_range(0, 1) == 1)
          it.first_word[15:8] = copper_line[7:0] + 8'($urandom_range(0, 40)) - 8'd8;
        if (tame) it.first_word[15:8] = 8'h00;
      end
      OP_SKIP: begin
        it.first_word[0] = 1'b1;
        it.second_word[0] = 1'b1;
      end
      default: begin
        it.first_word = END_FIRST;
        it.second_word = END_SECOND;
      end
    endcase
    return it;
  endfunction

  task automatic add_row(input logic [1:0] k, input logic [8:0] ln, input logic [18:0] sa,
                         input logic [15:0] w1, input logic [15:0] w2,
                         input bit typed, input result_t exp);
    directed_row_t row;
    row.it = '{k, ln, sa, w1, w2};
    row.typed = typed;
    row.exp = exp;
    directed_rows.push_back(row);
  endtask

  // Offer one transaction and hold it until accepted. Valid stays high
  // into the next call when that call draws no gap, so it is never
  // dropped and raised again in one time step.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_exp);
    int      gap;
    result_t predicted;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= it.kind;
    item_ch.line_number <= it.line_number;
    item_ch.start_address <= it.start_address;
    item_ch.first_word <= it.first_word;
    item_ch.second_word <= it.second_word;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    predicted = copper_step(it);
    copper_status_q.push_back(typed ? typed_exp : predicted);
  endtask

  // Drop valid and wait until every expected status word has come back.
  task automatic drain_results();
    int waited;
    item_ch.valid <= 1'b0;
    waited = 0;
    while (copper_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (copper_status_q.size() != 0) begin
      $error("%0d expected results never arrived", copper_status_q.size());
      mismatch_count++;
    end
  endtask

  task automatic check_status(input result_t want, input result_t got);
    if (got.write_valid !== want.write_valid) begin
      $error("write_valid: expected %0h, got %0h", want.write_valid, got.write_valid);
      mismatch_count++;
    end
    if (got.write_register !== want.write_register) begin
      $error("write_register: expected %0h, got %0h", want.write_register, got.write_register);
      mismatch_count++;
    end
    if (got.write_data !== want.write_data) begin
      $error("write_data: expected %0h, got %0h", want.write_data, got.write_data);
      mismatch_count++;
    end
    if (got.fetch_valid !== want.fetch_valid) begin
      $error("fetch_valid: expected %0h, got %0h", want.fetch_valid, got.fetch_valid);
      mismatch_count++;
    end
    if (got.fetch_address !== want.fetch_address) begin
      $error("fetch_address: expected %0h, got %0h", want.fetch_address, got.fetch_address);
      mismatch_count++;
    end
    if (got.halted !== want.halted) begin
      $error("halted: expected %0h, got %0h", want.halted, got.halted);
      mismatch_count++;
    end
    if (got.wake_line !== want.wake_line) begin
      $error("wake_line: expected %0h, got %0h", want.wake_line, got.wake_line);
      mismatch_count++;
    end
  endtask

  // Drive every block input to a known value from time zero.
  initial begin
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_FRAME;
    item_ch.line_number <= '0;
    item_ch.start_address <= '0;
    item_ch.first_word <= '0;
    item_ch.second_word <= '0;
    result_ch.ready <= 1'b0;
  end

  // Hold reset from time zero, once, then release it for good.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off that backs the block up
  // into its input, and an in-order compare against the expectations.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int      gap;
    int      held;
    result_t got;
    result_t want;
    wait (rst == 1'b0);
    forever begin
      if (results_seen == HOLD_AT_RESULT) begin
        // Hold ready low long enough for the pipeline to fill and stall.
        result_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else begin
        if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
        gap = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got = '{result_ch.write_valid, result_ch.write_register, result_ch.write_data,
              result_ch.fetch_valid, result_ch.fetch_address, result_ch.halted,
              result_ch.wake_line};
      results_seen++;
      if (copper_status_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatch_count++;
      end else begin
        want = copper_status_q.pop_front();
        check_status(want, got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then random frames.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    item_t it;
    int    ln;
    int    burst;
    int    k;
    int    pick;

    copper_pc = '0;
    list_one = '0;
    list_two = '0;
    copper_wake = '0;
    copper_stopped = 1'b1;
    copper_running = 1'b0;
    copper_line = '0;
    line_instr_count = '0;

    // Before any frame start everything is ignored.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0000, 16'hffff, 1'b1, AFTER_RESET);
    add_row(KIND_LINE, 9'h1ff, 19'h00000, 16'h0000, 16'h0000, 1'b1, AFTER_RESET);
    add_row(KIND_UNUSED, 9'h1ff, 19'h7ffff, 16'hffff, 16'hffff, 1'b1, AFTER_RESET);
    // Frame start at the top of chip memory, wake on line 0.
    add_row(KIND_FRAME, 9'h000, 19'h7ffff, 16'h0000, 16'h0000, 1'b1,
            '{1'b0, 9'h000, 16'h0000, 1'b0, 19'h7ffff, 1'b0, 10'h000});
    add_row(KIND_LINE, 9'h000, 19'h00000, 16'h0000, 16'h0000, 1'b1,
            '{1'b0, 9'h000, 16'h0000, 1'b1, 19'h7ffff, 1'b0, 10'h000});
    // MOVE to the highest register; the counter wraps past the end.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h01fe, 16'hffff, 1'b1,
            '{1'b1, 9'h1fe, 16'hffff, 1'b1, 19'h00003, 1'b0, 10'h000});
    // Load both list addresses.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0080, 16'hffff, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0082, 16'hffff, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0084, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0086, 16'h1235, 1'b0, NO_STATUS);
    // WAIT that passes, SKIP that passes, SKIP that fails.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0001, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0001, 16'h0001, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'hff01, 16'hff01, 1'b0, NO_STATUS);
    // Jump through list one; the copper sleeps until line 1.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0088, 16'h0000, 1'b1,
            '{1'b1, 9'h088, 16'h0000, 1'b0, 19'h7fffe, 1'b0, 10'h001});
    // Instruction while asleep is ignored.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_LINE, 9'h001, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h008a, 16'h5a5a, 1'b0, NO_STATUS);
    add_row(KIND_LINE, 9'h002, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    // WAIT that fails, then a line short of the target, then a line past it.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0a01, 16'h7f00, 1'b0, NO_STATUS);
    add_row(KIND_LINE, 9'h009, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_LINE, 9'd200, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    // Masked WAIT fails although its target is behind: wrap to next half.
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'hbf01, 16'h0f00, 1'b0, NO_STATUS);
    add_row(KIND_LINE, 9'd447, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    // Line start while still running restarts the instruction count.
    add_row(KIND_LINE, 9'd448, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    // End of list, then an instruction while halted.
    add_row(KIND_INSTR, 9'h000, 19'h00000, END_FIRST, END_SECOND, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    // A new frame clears the lists: a jump lands on address zero.
    add_row(KIND_FRAME, 9'h000, 19'h00000, 16'h0000, 16'h0000, 1'b1,
            '{1'b0, 9'h000, 16'h0000, 1'b0, 19'h00000, 1'b0, 10'h000});
    add_row(KIND_LINE, 9'h000, 19'h00000, 16'h0000, 16'h0000, 1'b0, NO_STATUS);
    add_row(KIND_INSTR, 9'h000, 19'h00000, 16'h0088, 16'h0000, 1'b1,
            '{1'b1, 9'h088, 16'h0000, 1'b0, 19'h00000, 1'b0, 10'h001});

    wait (rst == 1'b0);
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].exp);
    drain_results();

    // Random frames: mostly well-formed line starts each followed by a
    // burst of instructions, with some noise sprinkled in.
    while (items_sent < TOTAL_ITEMS) begin
      it = rand_fields();
      it.kind = KIND_FRAME;
      send_item(it, 1'b0, NO_STATUS);
      ln = $urandom_range(0, 3);
      while (ln <= 511 && items_sent < TOTAL_ITEMS) begin
        it = rand_fields();
        it.kind = KIND_LINE;
        it.line_number = 9'(ln);
        send_item(it, 1'b0, NO_STATUS);
        burst = $urandom_range(0, 7);
        for (k = 0; k < burst; k++) begin
          // Mostly stop feeding pairs once the copper has gone to sleep.
          if (!copper_running && $urandom_range(0, 4) != 0) break;
          pick = $urandom_range(0, 99);
          send_item(make_instr(pick < 50 ? OP_MOVE : (pick < 75 ? OP_WAIT :
                               (pick < 97 ? OP_SKIP : OP_END)), 1'b0), 1'b0, NO_STATUS);
        end
        if ($urandom_range(0, 15) == 0) begin
          it = rand_fields();
          it.kind = ($urandom_range(0, 1) == 1) ? KIND_UNUSED : KIND_INSTR;
          send_item(it, 1'b0, NO_STATUS);
        end
        if (copper_stopped && $urandom_range(0, 2) != 0) break;
        ln += ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 12);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results: %0d register writes, %0d sleeps,",
             items_sent, results_seen, move_count, sleep_count);
    $display("%0d end-of-list halts, with idle gaps, stalls and one long output hold-off.",
             halt_count);
    if (mismatch_count == 0) begin
      $display("** display_list_coprocessor: PASSED **");
    end else begin
      $display("** display_list_coprocessor: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("** display_list_coprocessor: FAILED **");
    $finish;
  end

endmodule
